// File: rtl/pidarr_pkg.sv
package pidarr_pkg;

  localparam int AXES_DEF      = 3;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_AXES      = 3;
  localparam int REG_W         = 31;

  localparam logic [REG_W-1:0] GAIN_P_RST = 31'd65536;
  localparam logic [REG_W-1:0] GAIN_I_RST = 31'd0;
  localparam logic [REG_W-1:0] GAIN_D_RST = 31'd0;
  localparam logic [REG_W-1:0] RADIUS_RST = 31'd65536;

  typedef enum logic [1:0] {
    REG_GAIN_P = 2'd0,
    REG_GAIN_I = 2'd1,
    REG_GAIN_D = 2'd2,
    REG_RADIUS = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic near;
  } lane_stat_t;

endpackage

// File: rtl/pidarr_if.sv
interface pidarr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] set_x;
  logic signed [31:0] set_y;
  logic signed [31:0] set_z;
  logic signed [31:0] meas_x;
  logic signed [31:0] meas_y;
  logic signed [31:0] meas_z;
  logic [30:0]        elapsed;

  modport source (output valid, set_x, set_y, set_z, meas_x, meas_y, meas_z, elapsed,
                  input ready);
  modport sink   (input valid, set_x, set_y, set_z, meas_x, meas_y, meas_z, elapsed,
                  output ready);
endinterface

interface pidarr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cmd_x;
  logic signed [31:0] cmd_y;
  logic signed [31:0] cmd_z;
  logic               inside_box;
  logic               arrival_pulse;
  logic               zero_elapsed;

  modport source (output valid, cmd_x, cmd_y, cmd_z, inside_box, arrival_pulse,
                  zero_elapsed, input ready);
  modport sink   (input valid, cmd_x, cmd_y, cmd_z, inside_box, arrival_pulse,
                  zero_elapsed, output ready);
endinterface

// File: rtl/pidarr_lane.sv
module pidarr_lane
  import pidarr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               release_res,
  input  logic signed [31:0] set_pos,
  input  logic signed [31:0] meas_pos,
  input  logic [30:0]        elapsed,
  input  logic [30:0]        gain_p,
  input  logic [30:0]        gain_i,
  input  logic [30:0]        gain_d,
  input  logic [30:0]        radius,
  output lane_stat_t         stat,
  output logic signed [31:0] cmd
);

  localparam int NUMW = 34 + FRAC_BITS;
  localparam int CNTW = $clog2(NUMW + 1);
  localparam logic [63:0] HI_LIMIT   = 64'd1 << (30 + FRAC_BITS);
  localparam logic [63:0] TERM_LIMIT = 64'd1 << 62;
  localparam logic signed [47:0] S48_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] S48_MIN = {1'b1, {47{1'b0}}};

  typedef enum logic [5:0] {
    L_IDLE = 6'b000001,
    L_DIV  = 6'b000010,
    L_MLO  = 6'b000100,
    L_MHI  = 6'b001000,
    L_ACC  = 6'b010000,
    L_DONE = 6'b100000
  } lane_state_t;

  lane_state_t        state;
  logic [CNTW-1:0]    cnt;
  logic [1:0]         op;
  logic signed [32:0] err;
  logic signed [32:0] last_err;
  logic signed [47:0] integ;
  logic signed [47:0] deriv;
  logic signed [63:0] pterm, iterm, dterm;
  logic [NUMW-1:0]    dvd;
  logic [30:0]        rem;
  logic [30:0]        dt;
  logic               dneg;
  logic               near;
  logic [62:0]        plo;
  logic [46:0]        phi;

  logic signed [32:0] e_new;
  logic signed [33:0] diff;
  logic [33:0]        diff_mag;
  logic [32:0]        e_mag;
  logic [31:0]        trial;
  logic               ge;
  logic [NUMW-1:0]    q_fin;
  logic [63:0]        q64;
  logic signed [47:0] d_fin;
  logic [30:0]        mg;
  logic signed [47:0] mv;
  logic               vneg;
  logic [47:0]        vmag;
  logic [63:0]        r;
  logic signed [63:0] term;
  logic signed [64:0] isum;
  logic signed [47:0] integ_next;
  logic signed [65:0] csum;

  always_comb begin
    e_new    = 33'(set_pos) - 33'(meas_pos);
    diff     = 34'(e_new) - 34'(last_err);
    diff_mag = diff[33] ? 34'(-diff) : 34'(diff);
    e_mag    = e_new[32] ? 33'(-e_new) : 33'(e_new);
    trial    = {rem, dvd[NUMW-1]};
    ge       = trial >= {1'b0, dt};
    q_fin    = {dvd[NUMW-2:0], ge};
    q64      = 64'(q_fin);
    if (|q64[63:47]) begin
      d_fin = dneg ? S48_MIN : S48_MAX;
    end else begin
      d_fin = dneg ? 48'(-$signed({1'b0, q64[46:0]})) : $signed({1'b0, q64[46:0]});
    end
  end

  always_comb begin
    case (op)
      2'd0: begin
        mg = dt;
        mv = 48'(err);
      end
      2'd1: begin
        mg = gain_p;
        mv = 48'(err);
      end
      2'd2: begin
        mg = gain_i;
        mv = integ;
      end
      default: begin
        mg = gain_d;
        mv = deriv;
      end
    endcase
    vneg = mv[47];
    vmag = vneg ? 48'(-mv) : 48'(mv);
    if (64'(phi) >= HI_LIMIT) begin
      r = TERM_LIMIT;
    end else begin
      r = (64'(phi) << (32 - FRAC_BITS)) + 64'(plo >> FRAC_BITS);
      if (r > TERM_LIMIT) r = TERM_LIMIT;
    end
    term = vneg ? -$signed(r) : $signed(r);
    isum = 65'(integ) + 65'(term);
    if (isum > 65'(S48_MAX)) integ_next = S48_MAX;
    else if (isum < 65'(S48_MIN)) integ_next = S48_MIN;
    else integ_next = isum[47:0];
    csum = 66'(pterm) + 66'(iterm) + 66'(dterm);
    if (csum > 66'sd2147483647) cmd = 32'sh7fffffff;
    else if (csum < -66'sd2147483648) cmd = 32'sh80000000;
    else cmd = csum[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= L_IDLE;
      integ    <= '0;
      last_err <= '0;
      cnt      <= '0;
      op       <= '0;
    end else begin
      case (state)
        L_IDLE: begin
          if (start) begin
            err      <= e_new;
            last_err <= e_new;
            near     <= {1'b0, e_mag} < 34'(radius);
            op       <= 2'd0;
            dneg     <= diff[33];
            dvd      <= NUMW'(diff_mag) << FRAC_BITS;
            rem      <= '0;
            dt       <= elapsed;
            cnt      <= CNTW'(NUMW);
            if (elapsed == '0) begin
              deriv <= '0;
              state <= L_MLO;
            end else begin
              state <= L_DIV;
            end
          end
        end
        L_DIV: begin
          rem <= ge ? 31'(trial - {1'b0, dt}) : trial[30:0];
          dvd <= q_fin;
          cnt <= cnt - 1'b1;
          if (cnt == CNTW'(1)) begin
            deriv <= d_fin;
            state <= L_MLO;
          end
        end
        L_MLO: begin
          plo   <= 63'(mg) * 63'(vmag[31:0]);
          state <= L_MHI;
        end
        L_MHI: begin
          phi   <= 47'(mg) * 47'(vmag[47:32]);
          state <= L_ACC;
        end
        L_ACC: begin
          case (op)
            2'd0: integ <= integ_next;
            2'd1: pterm <= term;
            2'd2: iterm <= term;
            default: dterm <= term;
          endcase
          op    <= op + 1'b1;
          state <= (op == 2'd3) ? L_DONE : L_MLO;
        end
        L_DONE: begin
          if (release_res) state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  assign stat.idle = (state == L_IDLE);
  assign stat.done = (state == L_DONE);
  assign stat.near = near;

endmodule

// File: rtl/three_axis_pid_with_arrival_pulse_unit.sv
// Each axis lane runs a bit-serial divider for the derivative (skipped when
// elapsed is zero), then four multiply-accumulate passes: integral, P, I, D.
// A new transaction is accepted only once every lane is idle again, after the
// previous result has moved into the output register; a result that waits on
// out_ch.ready holds new input off. Lanes run side by side, one per axis.
// Reset: synchronous, clears integrals, last errors, arrival latch and
// restores register defaults.
module three_axis_pid_with_arrival_pulse_unit
  import pidarr_pkg::*;
#(
  parameter int AXES      = AXES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  pidarr_in_if.sink        in_ch,
  pidarr_out_if.source     out_ch,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [REG_W-1:0] cfg_data
);

  logic [REG_W-1:0] gain_p, gain_i, gain_d, radius;
  lane_stat_t         stat  [MAX_AXES];
  logic signed [31:0] cmd_l [MAX_AXES];
  logic signed [31:0] set_a [MAX_AXES];
  logic signed [31:0] meas_a[MAX_AXES];
  logic [MAX_AXES-1:0] idle_v, done_v, near_v;
  logic start, merge_go, latch, zdt;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p <= GAIN_P_RST;
      gain_i <= GAIN_I_RST;
      gain_d <= GAIN_D_RST;
      radius <= RADIUS_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_GAIN_P: gain_p <= cfg_data;
        REG_GAIN_I: gain_i <= cfg_data;
        REG_GAIN_D: gain_d <= cfg_data;
        REG_RADIUS: radius <= cfg_data;
        default: ;
      endcase
    end
  end

  assign set_a  = '{in_ch.set_x, in_ch.set_y, in_ch.set_z};
  assign meas_a = '{in_ch.meas_x, in_ch.meas_y, in_ch.meas_z};

  assign in_ch.ready = &idle_v;
  assign start       = in_ch.valid & in_ch.ready;
  assign merge_go    = (&done_v) & (~out_ch.valid | out_ch.ready);

  for (genvar i = 0; i < MAX_AXES; i++) begin : g_lane
    if (i < AXES) begin : g_on
      pidarr_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
        .clk        (clk),
        .rst        (rst),
        .start      (start),
        .release_res(merge_go),
        .set_pos    (set_a[i]),
        .meas_pos   (meas_a[i]),
        .elapsed    (in_ch.elapsed),
        .gain_p     (gain_p),
        .gain_i     (gain_i),
        .gain_d     (gain_d),
        .radius     (radius),
        .stat       (stat[i]),
        .cmd        (cmd_l[i])
      );
    end else begin : g_off
      assign stat[i]  = '{idle: 1'b1, done: 1'b1, near: 1'b1};
      assign cmd_l[i] = '0;
    end
    assign idle_v[i] = stat[i].idle;
    assign done_v[i] = stat[i].done;
    assign near_v[i] = stat[i].near;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      latch        <= 1'b0;
    end else begin
      if (start) zdt <= (in_ch.elapsed == '0);
      if (merge_go) begin
        out_ch.valid         <= 1'b1;
        out_ch.cmd_x         <= cmd_l[0];
        out_ch.cmd_y         <= cmd_l[1];
        out_ch.cmd_z         <= cmd_l[2];
        out_ch.inside_box    <= &near_v;
        out_ch.arrival_pulse <= (&near_v) & ~latch;
        out_ch.zero_elapsed  <= zdt;
        latch                <= &near_v;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

endmodule

// File: sim/tb.sv
module tb;
  import pidarr_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam wide_t I64_MAX  = 128'sh7fff_ffff_ffff_ffff;
  localparam wide_t I64_MIN  = -I64_MAX - 1;
  localparam wide_t I48_MAX  = 128'sh7fff_ffff_ffff;
  localparam wide_t I48_MIN  = -I48_MAX - 1;
  localparam wide_t I32_MAX  = 128'sh7fff_ffff;
  localparam wide_t I32_MIN  = -I32_MAX - 1;
  localparam wide_t TERM_CAP = 128'sh4000_0000_0000_0000;
  localparam int    CYCLE_LIMIT = 1000000;
  localparam int    N_RANDOM    = 2000;

  typedef struct {
    logic signed [31:0] sp [3];
    logic signed [31:0] pos [3];
    logic [30:0]        dt;
    bit                 typed;
    logic signed [31:0] t_cmd [3];
    logic               t_inside;
    logic               t_pulse;
    logic               t_zero;
  } tick_t;

  typedef struct {
    logic signed [31:0] cmd [3];
    logic               in_radius;
    logic               pulse;
    logic               zero;
  } command_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  pidarr_in_if  in_ch();
  pidarr_out_if out_ch();

  three_axis_pid_with_arrival_pulse_unit DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  logic [30:0] kp, ki, kd, radius;
  wide_t integ [3];
  wide_t last_err [3];
  bit arrived;

  command_t pending_cmds [$];
  tick_t directed_rows [$];
  int errors = 0;
  int cycles = 0;
  bit no_gaps = 0;

  function automatic wide_t clampw(wide_t v, wide_t lo, wide_t hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic wide_t scaled_product(logic [30:0] g, wide_t v);
    wide_t gw, mag, r;
    gw = wide_t'({97'b0, g});
    mag = v < 0 ? -v : v;
    r = (gw * mag) >>> 16;
    if (r > TERM_CAP) r = TERM_CAP;
    return v < 0 ? -r : r;
  endfunction

  function automatic wide_t sat_add(wide_t a, wide_t b);
    return clampw(a + b, I64_MIN, I64_MAX);
  endfunction

  function automatic command_t control_step(tick_t t);
    command_t r;
    wide_t e, mag, d, c;
    bit in_box;
    in_box = 1;
    for (int i = 0; i < 3; i++) begin
      e = wide_t'(t.sp[i]) - wide_t'(t.pos[i]);
      mag = e < 0 ? -e : e;
      if (!(mag < wide_t'({97'b0, radius}))) in_box = 0;
      integ[i] = clampw(sat_add(integ[i], scaled_product(t.dt, e)), I48_MIN, I48_MAX);
      if (t.dt == 0) begin
        d = 0;
      end else begin
        d = clampw(((e - last_err[i]) * 65536) / wide_t'({97'b0, t.dt}), I48_MIN, I48_MAX);
      end
      last_err[i] = e;
      c = sat_add(scaled_product(kp, e), scaled_product(ki, integ[i]));
      c = sat_add(c, scaled_product(kd, d));
      r.cmd[i] = 32'(clampw(c, I32_MIN, I32_MAX));
    end
    r.pulse = 0;
    if (in_box) begin
      if (!arrived) begin
        arrived = 1;
        r.pulse = 1;
      end
    end else begin
      arrived = 0;
    end
    r.in_radius = in_box;
    r.zero = (t.dt == 0);
    return r;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [30:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_GAIN_P: kp = val;
      REG_GAIN_I: ki = val;
      REG_GAIN_D: kd = val;
      REG_RADIUS: radius = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_ch.valid <= 0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic configure(logic [30:0] p, logic [30:0] i, logic [30:0] d, logic [30:0] rad);
    wait_drained();
    write_reg(REG_GAIN_P, p);
    write_reg(REG_GAIN_I, i);
    write_reg(REG_GAIN_D, d);
    write_reg(REG_RADIUS, rad);
    cfg_we <= 0;
  endtask

  task automatic send_tick(tick_t t);
    command_t r;
    if (!no_gaps && $urandom_range(0, 99) < 21) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.set_x <= t.sp[0];
    in_ch.set_y <= t.sp[1];
    in_ch.set_z <= t.sp[2];
    in_ch.meas_x <= t.pos[0];
    in_ch.meas_y <= t.pos[1];
    in_ch.meas_z <= t.pos[2];
    in_ch.elapsed <= t.dt;
    do @(posedge clk); while (!in_ch.ready);
    r = control_step(t);
    if (t.typed) begin
      r.cmd = t.t_cmd;
      r.in_radius = t.t_inside;
      r.pulse = t.t_pulse;
      r.zero = t.t_zero;
    end
    pending_cmds.push_back(r);
  endtask

  function automatic logic [30:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 31'd0;
      1: return 31'd65536;
      2: return 31'h7fffffff;
      3: return 31'($urandom_range(0, 31'h7fffffff));
      default: return 31'($urandom_range(0, 1 << 19));
    endcase
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    int delta;
    t.typed = 0;
    for (int i = 0; i < 3; i++) begin
      t.sp[i] = $urandom();
      if ($urandom_range(0, 99) < 70) begin
        delta = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1 << 20)
                                          : $urandom_range(0, 1 << 17);
        if ($urandom_range(0, 1)) delta = -delta;
        t.pos[i] = t.sp[i] - delta;
      end else begin
        t.pos[i] = $urandom();
      end
    end
    case ($urandom_range(0, 9))
      0: t.dt = 0;
      1, 2, 3: t.dt = 31'($urandom_range(0, 31'h7fffffff));
      default: t.dt = 31'($urandom_range(1, 1 << 17));
    endcase
    return t;
  endfunction

  function automatic tick_t row(int sx, int mx, logic [30:0] dt, bit typed,
                                int cx, bit ins, bit pul, bit zr);
    tick_t t;
    t.sp = '{sx, 0, 0};
    t.pos = '{mx, 0, 0};
    t.dt = dt;
    t.typed = typed;
    t.t_cmd = '{cx, 0, 0};
    t.t_inside = ins;
    t.t_pulse = pul;
    t.t_zero = zr;
    return t;
  endfunction

  always @(posedge clk) begin
    if (!rst) out_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 21);
  end

  always @(posedge clk) begin
    command_t exp_cmd;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected transaction cmd_x=%h", $time, out_ch.cmd_x);
        errors++;
      end else begin
        exp_cmd = pending_cmds.pop_front();
        if (out_ch.cmd_x !== exp_cmd.cmd[0]) begin
          $display("%0t: cmd_x expected %h actual %h", $time, exp_cmd.cmd[0], out_ch.cmd_x);
          errors++;
        end
        if (out_ch.cmd_y !== exp_cmd.cmd[1]) begin
          $display("%0t: cmd_y expected %h actual %h", $time, exp_cmd.cmd[1], out_ch.cmd_y);
          errors++;
        end
        if (out_ch.cmd_z !== exp_cmd.cmd[2]) begin
          $display("%0t: cmd_z expected %h actual %h", $time, exp_cmd.cmd[2], out_ch.cmd_z);
          errors++;
        end
        if (out_ch.inside_box !== exp_cmd.in_radius) begin
          $display("%0t: inside_box expected %b actual %b", $time, exp_cmd.in_radius,
                   out_ch.inside_box);
          errors++;
        end
        if (out_ch.arrival_pulse !== exp_cmd.pulse) begin
          $display("%0t: arrival_pulse expected %b actual %b", $time, exp_cmd.pulse,
                   out_ch.arrival_pulse);
          errors++;
        end
        if (out_ch.zero_elapsed !== exp_cmd.zero) begin
          $display("%0t: zero_elapsed expected %b actual %b", $time, exp_cmd.zero,
                   out_ch.zero_elapsed);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 0;
    in_ch.set_x = 0;
    in_ch.set_y = 0;
    in_ch.set_z = 0;
    in_ch.meas_x = 0;
    in_ch.meas_y = 0;
    in_ch.meas_z = 0;
    in_ch.elapsed = 0;
    out_ch.ready = 0;
    kp = GAIN_P_RST;
    ki = GAIN_I_RST;
    kd = GAIN_D_RST;
    radius = RADIUS_RST;
    for (int i = 0; i < 3; i++) begin
      integ[i] = 0;
      last_err[i] = 0;
    end
    arrived = 0;

    // reset defaults: unity P gain, radius of 1.0 (65536)
    directed_rows.push_back(row(0, 0, 31'd65536, 1, 0, 1, 1, 0));
    directed_rows.push_back(row(0, 0, 31'd0, 1, 0, 1, 0, 1));
    directed_rows.push_back(row(32'sh7fffffff, 32'sh80000000, 31'd1, 1,
                                32'sh7fffffff, 0, 0, 0));
    directed_rows.push_back(row(32'sh80000000, 32'sh7fffffff, 31'h7fffffff, 1,
                                32'sh80000000, 0, 0, 0));
    directed_rows.push_back(row(0, 0, 31'd1, 1, 0, 1, 1, 0));
    directed_rows.push_back(row(0, 32'sd65535, 31'd1, 1, 32'sh80000000 + 32'sh7fff0001,
                                1, 0, 0));
    directed_rows.push_back(row(0, 32'sd65536, 31'd1, 0, 0, 0, 0, 0));

    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (directed_rows[k]) send_tick(directed_rows[k]);

    configure(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
    send_tick(row(32'sh7fffffff, 32'sh80000000, 31'd1, 0, 0, 0, 0, 0));
    send_tick(row(32'sh80000000, 32'sh7fffffff, 31'd1, 0, 0, 0, 0, 0));
    send_tick(row(32'sh80000000, 32'sh7fffffff, 31'd0, 0, 0, 0, 0, 0));
    send_tick(row(32'sh7fffffff, 32'sh80000000, 31'h7fffffff, 0, 0, 0, 0, 0));
    send_tick(row(5, 3, 31'd1, 0, 0, 0, 0, 0));
    send_tick(row(-5, 3, 31'd0, 0, 0, 0, 0, 0));

    configure(31'd0, 31'd0, 31'd0, 31'd0);
    send_tick(row(0, 0, 31'd65536, 0, 0, 0, 0, 0));
    send_tick(row(7, 7, 31'd0, 0, 0, 0, 0, 0));

    for (int ph = 0; ph < 10; ph++) begin
      configure(pick_gain(), pick_gain(), pick_gain(),
                $urandom_range(0, 3) == 0 ? pick_gain() : 31'($urandom_range(0, 1 << 18)));
      no_gaps = (ph == 4);
      for (int n = 0; n < N_RANDOM / 10; n++) send_tick(random_tick());
    end
    in_ch.valid <= 0;
    no_gaps = 0;

    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
